// ----- rtl/sbcn_pkg.sv -----
// sbcn_pkg: widths, register and normal codes, and stage records of the
// sphere/box collision normal pipeline
// no dependencies
package sbcn_pkg;

  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 12;
  localparam int SIZE_W    = 23;
  localparam int RAD_W     = 20;
  localparam int HGT_W     = 23;
  localparam int W2        = COORD_W + 4;
  localparam int W20       = W2 + 5;
  localparam int SQ_W      = 2 * W2;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic signed [W20-1:0] TOL20 = W20'(64'sd2 <<< FRAC_BITS);
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(64'd1 << FRAC_BITS);

  typedef enum logic [2:0] {
    REG_CX = 3'd0,
    REG_CY = 3'd1,
    REG_CZ = 3'd2,
    REG_SX = 3'd3,
    REG_SY = 3'd4,
    REG_SZ = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    NORM_NONE  = 3'd0,
    NORM_POS_Y = 3'd1,
    NORM_NEG_Y = 3'd2,
    NORM_NEG_X = 3'd3,
    NORM_POS_X = 3'd4,
    NORM_NEG_Z = 3'd5,
    NORM_POS_Z = 3'd6
  } norm_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [SIZE_W-1:0]         sx;
    logic [SIZE_W-1:0]         sy;
    logic [SIZE_W-1:0]         sz;
  } box_cfg_t;

  // all coordinates scaled by 2
  typedef struct packed {
    logic signed [W2-1:0] minx2;
    logic signed [W2-1:0] maxx2;
    logic signed [W2-1:0] miny2;
    logic signed [W2-1:0] maxy2;
    logic signed [W2-1:0] minz2;
    logic signed [W2-1:0] maxz2;
    logic signed [W2-1:0] px2;
    logic signed [W2-1:0] pz2;
    logic signed [W2-1:0] pminy2;
    logic signed [W2-1:0] pmaxy2;
    logic signed [W2-1:0] cy2;
    logic [RAD_W-1:0]     r;
  } s1_t;

  typedef struct packed {
    logic                  reject;
    logic                  land;
    logic [W2-1:0]         adx;
    logic [W2-1:0]         ady;
    logic [W2-1:0]         adz;
    logic [W2-1:0]         r2;
    logic [5:0][W2-1:0]    d;
  } s2_t;

  typedef struct packed {
    logic            reject;
    logic            land;
    logic [SQ_W-1:0] sqx;
    logic [SQ_W-1:0] sqy;
    logic [SQ_W-1:0] sqz;
    logic [SQ_W-1:0] sqr;
    logic [W2-1:0]   c0_val;
    norm_t           c0_code;
    logic [W2-1:0]   c1_val;
    norm_t           c1_code;
    logic [W2-1:0]   c2_val;
    norm_t           c2_code;
  } s3_t;

endpackage

// ----- rtl/sbcn_regs.sv -----
// sbcn_regs: box centre and size registers behind the apb port
// depends on sbcn_pkg
module sbcn_regs import sbcn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output box_cfg_t          box
);

  box_cfg_t box_r;
  box_cfg_t box_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign box    = box_r;

  always_comb begin
    box_nxt = box_r;
    if (wr) begin
      case (idx)
        REG_CX:  box_nxt.cx = pwdata[COORD_W-1:0];
        REG_CY:  box_nxt.cy = pwdata[COORD_W-1:0];
        REG_CZ:  box_nxt.cz = pwdata[COORD_W-1:0];
        REG_SX:  box_nxt.sx = pwdata[SIZE_W-1:0];
        REG_SY:  box_nxt.sy = pwdata[SIZE_W-1:0];
        REG_SZ:  box_nxt.sz = pwdata[SIZE_W-1:0];
        default: box_nxt = box_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.cx <= '0;
      box_r.cy <= '0;
      box_r.cz <= '0;
      box_r.sx <= SIZE_RST;
      box_r.sy <= SIZE_RST;
      box_r.sz <= SIZE_RST;
    end else begin
      box_r <= box_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_CX:  prdata = DATA_W'(box_r.cx);
      REG_CY:  prdata = DATA_W'(box_r.cy);
      REG_CZ:  prdata = DATA_W'(box_r.cz);
      REG_SX:  prdata = DATA_W'(box_r.sx);
      REG_SY:  prdata = DATA_W'(box_r.sy);
      REG_SZ:  prdata = DATA_W'(box_r.sz);
      default: prdata = '0;
    endcase
  end

endmodule

// ----- rtl/sbcn_front.sv -----
// sbcn_front: first stage, box bounds and player span at scale 2
// depends on sbcn_pkg
module sbcn_front import sbcn_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  box_cfg_t                  box,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] pos_z,
  input  logic [RAD_W-1:0]          body_radius,
  input  logic [HGT_W-1:0]          body_height,
  output s1_t                       s1
);

  logic signed [W2-1:0] cx_w, cy_w, cz_w, sx_w, sy_w, sz_w;
  logic signed [W2-1:0] px_w, py_w, pz_w, r_w, h_w;
  s1_t s1_r;
  s1_t s1_nxt;

  assign cx_w = W2'(box.cx);
  assign cy_w = W2'(box.cy);
  assign cz_w = W2'(box.cz);
  assign sx_w = signed'(W2'(box.sx));
  assign sy_w = signed'(W2'(box.sy));
  assign sz_w = signed'(W2'(box.sz));
  assign px_w = W2'(pos_x);
  assign py_w = W2'(pos_y);
  assign pz_w = W2'(pos_z);
  assign r_w  = signed'(W2'(body_radius));
  assign h_w  = signed'(W2'(body_height));

  always_comb begin
    s1_nxt.minx2  = (cx_w <<< 1) - sx_w;
    s1_nxt.maxx2  = (cx_w <<< 1) + sx_w;
    s1_nxt.miny2  = (cy_w <<< 1) - sy_w;
    s1_nxt.maxy2  = (cy_w <<< 1) + sy_w;
    s1_nxt.minz2  = (cz_w <<< 1) - sz_w;
    s1_nxt.maxz2  = (cz_w <<< 1) + sz_w;
    s1_nxt.px2    = px_w <<< 1;
    s1_nxt.pz2    = pz_w <<< 1;
    s1_nxt.pminy2 = (py_w - r_w) <<< 1;
    s1_nxt.pmaxy2 = (py_w + h_w + r_w) <<< 1;
    s1_nxt.cy2    = (py_w <<< 1) + h_w;
    s1_nxt.r      = body_radius;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

// ----- rtl/sbcn_classify.sv -----
// sbcn_classify: second stage, early reject, top landing, clamp offsets
// and face distances; depends on sbcn_pkg
module sbcn_classify import sbcn_pkg::*; (
  input  logic clk,
  input  logic en,
  input  s1_t  s1,
  output s2_t  s2
);

  function automatic logic signed [W20-1:0] mul10(input logic signed [W20-1:0] v);
    mul10 = (v <<< 3) + (v <<< 1);
  endfunction

  function automatic logic signed [W20-1:0] mul22(input logic signed [W20-1:0] v);
    mul22 = (v <<< 4) + (v <<< 2) + (v <<< 1);
  endfunction

  function automatic logic [W2-1:0] absv(input logic signed [W2-1:0] v);
    absv = v[W2-1] ? W2'(-v) : W2'(v);
  endfunction

  function automatic logic signed [W2-1:0] clampv(input logic signed [W2-1:0] v,
                                                  input logic signed [W2-1:0] lo,
                                                  input logic signed [W2-1:0] hi);
    if (lo > v) begin
      clampv = lo;
    end else if (hi < v) begin
      clampv = hi;
    end else begin
      clampv = v;
    end
  endfunction

  logic signed [W20-1:0] px20, pz20, er20;
  logic signed [W20-1:0] mnx20, mxx20, mnz20, mxz20;
  logic signed [W20-1:0] a20;
  logic signed [W2-1:0]  r2s, top_gap;
  logic                  rej_x, rej_y, rej_z, ovl_x, ovl_z;
  s2_t s2_r;
  s2_t s2_nxt;

  assign px20  = mul10(W20'(s1.px2));
  assign pz20  = mul10(W20'(s1.pz2));
  assign er20  = mul22(signed'(W20'(s1.r)));
  assign mnx20 = mul10(W20'(s1.minx2));
  assign mxx20 = mul10(W20'(s1.maxx2));
  assign mnz20 = mul10(W20'(s1.minz2));
  assign mxz20 = mul10(W20'(s1.maxz2));
  assign r2s   = signed'(W2'(s1.r)) <<< 1;

  assign rej_x = (px20 + er20 < mnx20) || (px20 - er20 > mxx20);
  assign rej_y = (s1.pmaxy2 < s1.miny2) || (s1.pminy2 > s1.maxy2);
  assign rej_z = (pz20 + er20 < mnz20) || (pz20 - er20 > mxz20);

  assign top_gap = s1.pminy2 - s1.maxy2;
  assign a20     = mul10(W20'(top_gap));
  assign ovl_x   = (s1.px2 + r2s > s1.minx2) && (s1.px2 - r2s < s1.maxx2);
  assign ovl_z   = (s1.pz2 + r2s > s1.minz2) && (s1.pz2 - r2s < s1.maxz2);

  always_comb begin
    s2_nxt.reject = rej_x || rej_y || rej_z;
    s2_nxt.land   = (a20 < TOL20) && (a20 > -TOL20) && ovl_x && ovl_z;
    s2_nxt.adx    = absv(clampv(s1.px2, s1.minx2, s1.maxx2) - s1.px2);
    s2_nxt.ady    = absv(clampv(s1.cy2, s1.miny2, s1.maxy2) - s1.cy2);
    s2_nxt.adz    = absv(clampv(s1.pz2, s1.minz2, s1.maxz2) - s1.pz2);
    s2_nxt.r2     = W2'(r2s);
    s2_nxt.d[0]   = absv(top_gap);
    s2_nxt.d[1]   = absv(s1.pmaxy2 - s1.miny2);
    s2_nxt.d[2]   = absv(s1.px2 + r2s - s1.minx2);
    s2_nxt.d[3]   = absv(s1.px2 - r2s - s1.maxx2);
    s2_nxt.d[4]   = absv(s1.pz2 + r2s - s1.minz2);
    s2_nxt.d[5]   = absv(s1.pz2 - r2s - s1.maxz2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2 = s2_r;

endmodule

// ----- rtl/sbcn_resolve.sv -----
// sbcn_resolve: third and fourth stages, squared distances, sphere test
// and nearest face selection; depends on sbcn_pkg
module sbcn_resolve import sbcn_pkg::*; (
  input  logic       clk,
  input  logic       en3,
  input  logic       en4,
  input  s2_t        s2,
  output logic       hit,
  output logic [2:0] normal_code
);

  s3_t   s3_r;
  s3_t   s3_nxt;
  logic  hit_r, hit_nxt;
  norm_t code_r, code_nxt;

  logic [SUM_W-1:0] d2;
  logic             sphere;
  logic [W2-1:0]    b_val;
  norm_t            b_code;
  norm_t            f_code;

  // ties keep the earlier face
  always_comb begin
    s3_nxt.reject = s2.reject;
    s3_nxt.land   = s2.land;
    s3_nxt.sqx    = s2.adx * s2.adx;
    s3_nxt.sqy    = s2.ady * s2.ady;
    s3_nxt.sqz    = s2.adz * s2.adz;
    s3_nxt.sqr    = s2.r2 * s2.r2;
    if (s2.d[1] < s2.d[0]) begin
      s3_nxt.c0_val  = s2.d[1];
      s3_nxt.c0_code = NORM_NEG_Y;
    end else begin
      s3_nxt.c0_val  = s2.d[0];
      s3_nxt.c0_code = NORM_POS_Y;
    end
    if (s2.d[3] < s2.d[2]) begin
      s3_nxt.c1_val  = s2.d[3];
      s3_nxt.c1_code = NORM_POS_X;
    end else begin
      s3_nxt.c1_val  = s2.d[2];
      s3_nxt.c1_code = NORM_NEG_X;
    end
    if (s2.d[5] < s2.d[4]) begin
      s3_nxt.c2_val  = s2.d[5];
      s3_nxt.c2_code = NORM_POS_Z;
    end else begin
      s3_nxt.c2_val  = s2.d[4];
      s3_nxt.c2_code = NORM_NEG_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_r <= s3_nxt;
    end
  end

  assign d2     = SUM_W'(s3_r.sqx) + SUM_W'(s3_r.sqy) + SUM_W'(s3_r.sqz);
  assign sphere = d2 < SUM_W'(s3_r.sqr);

  always_comb begin
    if (s3_r.c1_val < s3_r.c0_val) begin
      b_val  = s3_r.c1_val;
      b_code = s3_r.c1_code;
    end else begin
      b_val  = s3_r.c0_val;
      b_code = s3_r.c0_code;
    end
    if (s3_r.c2_val < b_val) begin
      f_code = s3_r.c2_code;
    end else begin
      f_code = b_code;
    end
  end

  always_comb begin
    if (s3_r.reject) begin
      hit_nxt  = 1'b0;
      code_nxt = NORM_NONE;
    end else if (s3_r.land) begin
      hit_nxt  = 1'b1;
      code_nxt = NORM_POS_Y;
    end else if (sphere) begin
      hit_nxt  = 1'b1;
      code_nxt = f_code;
    end else begin
      hit_nxt  = 1'b0;
      code_nxt = NORM_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      hit_r  <= hit_nxt;
      code_r <= code_nxt;
    end
  end

  assign hit         = hit_r;
  assign normal_code = code_r;

endmodule

// ----- rtl/sphere_box_collision_normal_unit.sv -----
// four register stages (s1, s2, s3, hit/code) carry a request in order
// throughput: one request per cycle while out_stall is low; each stage
// fills its own bubble so a stalled output only backs up a full pipeline
// reset (rst_n low, synchronous) empties the pipeline and sets the box
// to a unit cube centred on the origin
// depends on sbcn_pkg, sbcn_regs, sbcn_front, sbcn_classify, sbcn_resolve
module sphere_box_collision_normal_unit import sbcn_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic signed [COORD_W-1:0] in_pos_z,
  input  logic [RAD_W-1:0]          in_body_radius,
  input  logic [HGT_W-1:0]          in_body_height,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_hit,
  output logic [2:0]                out_normal_code,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  box_cfg_t box;
  s1_t      s1;
  s2_t      s2;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic v1_nxt, v2_nxt, v3_nxt, out_valid_nxt;
  logic en1, en2, en3, en4;

  assign en4 = !out_valid_r || !out_stall;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_stall  = !en1;
  assign out_valid = out_valid_r;

  always_comb begin
    v1_nxt        = en1 ? in_valid : v1_r;
    v2_nxt        = en2 ? v1_r : v2_r;
    v3_nxt        = en3 ? v2_r : v3_r;
    out_valid_nxt = en4 ? v3_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  sbcn_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .box     (box)
  );

  sbcn_front u_front (
    .clk         (clk),
    .en          (en1),
    .box         (box),
    .pos_x       (in_pos_x),
    .pos_y       (in_pos_y),
    .pos_z       (in_pos_z),
    .body_radius (in_body_radius),
    .body_height (in_body_height),
    .s1          (s1)
  );

  sbcn_classify u_classify (
    .clk (clk),
    .en  (en2),
    .s1  (s1),
    .s2  (s2)
  );

  sbcn_resolve u_resolve (
    .clk         (clk),
    .en3         (en3),
    .en4         (en4),
    .s2          (s2),
    .hit         (out_hit),
    .normal_code (out_normal_code)
  );

`ifndef SYNTHESIS
  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_hit == (out_normal_code != NORM_NONE)))
    else $error("hit flag and normal code disagree");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted request lost at first stage");
`endif

endmodule
